// ===== rtl/color_sensor_rgb_to_cct_lux_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the color sensor CCT / lux core
// Shared concurrent checks, clocked on clk with active-low rst_n.
// ----------------------------------------------------------------------------
`ifndef COLOR_SENSOR_RGB_TO_CCT_LUX_CORE_MACROS_SVH
`define COLOR_SENSOR_RGB_TO_CCT_LUX_CORE_MACROS_SVH

// same-cycle implication, off while in reset
`define CCL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, also active across reset
`define CCL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== rtl/ccl_pkg.sv =====
// ----------------------------------------------------------------------------
// ccl_pkg
// Shared types and fixed constants of the color sensor CCT / lux core.
// ----------------------------------------------------------------------------
package ccl_pkg;

  localparam int MAG_W  = 47;  // |num| and |den| magnitude width
  localparam int CH_W   = 16;
  localparam int DIVC_W = 9;   // per-sample channel divisor, up to 258

  // num = 10*(1000*X - 332*S), den = 1858*S - 10000*Y, per raw channel
  localparam logic signed [47:0] NUM_R = 48'sd238814000;
  localparam logic signed [47:0] NUM_G = 48'sd254991120;
  localparam logic signed [47:0] NUM_B = -48'sd582910000;
  localparam logic signed [47:0] DEN_R = 48'sd111082900;
  localparam logic signed [47:0] DEN_G = -48'sd854058428;
  localparam logic signed [47:0] DEN_B = 48'sd522885000;
  localparam logic signed [47:0] S_R   = -48'sd114950;
  localparam logic signed [47:0] S_G   = 48'sd389834;
  localparam logic signed [47:0] S_B   = -48'sd112500;
  localparam logic signed [47:0] Y_R   = -48'sd32466;
  localparam logic signed [47:0] Y_G   = 48'sd157837;
  localparam logic signed [47:0] Y_B   = -48'sd73191;

  localparam logic [31:0] RECIP255 = 32'd32897;      // m/255 = m*RECIP255 >> 23
  localparam logic signed [47:0] LUX_BIG = 48'sd6553600000;
  localparam logic [56:0] LUX_K    = 57'd351843721;  // (Y>>5)/3125 = *K >> 40
  localparam logic [7:0]  RGB_OFS  = 8'd30;
  localparam logic [26:0] RGB_K    = 27'd8739;       // w/15 = w*K >> 17
  localparam logic [31:0] CCT_BIG  = 32'd6553600;
  localparam logic [46:0] CCT_K    = 47'd10737419;   // x/100 = x*K >> 30
  localparam logic [15:0] SAT16    = 16'hFFFF;

  typedef logic [2:0][CH_W-1:0] chan_t;  // [0] red, [1] green, [2] blue
  typedef logic [2:0][7:0]      rgb_t;

  typedef struct packed {
    logic tv;   // both denominators nonzero
    logic neg;  // ratio negative
    logic sat;  // |ratio| >= 16
  } flags_t;

  typedef struct packed {
    rgb_t        rgb;
    logic [15:0] lux;
    logic        tv;
  } side_t;

endpackage

// ===== rtl/ccl_front.sv =====
// ----------------------------------------------------------------------------
// ccl_front
// Two stages: matrix products and channel divisor, then magnitudes, flags, lux.
// ----------------------------------------------------------------------------
module ccl_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        s_valid,
  output logic                        s_ready,
  input  ccl_pkg::chan_t              s_chan,
  output logic                        m_valid,
  input  logic                        m_ready,
  output ccl_pkg::chan_t              m_chan,
  output logic [ccl_pkg::DIVC_W-1:0]  m_cdiv,
  output logic [ccl_pkg::MAG_W-1:0]   m_num_mag,
  output logic [ccl_pkg::MAG_W-1:0]   m_den_mag,
  output ccl_pkg::flags_t             m_flags,
  output logic [15:0]                 m_lux
);
  import ccl_pkg::*;

  logic [1:0] v_r;
  logic [1:0] en;

  chan_t              chan1_r, chan2_r;
  logic [DIVC_W-1:0]  cdiv1_r, cdiv2_r, cdiv1_nxt;
  logic signed [47:0] num1_r, den1_r, s1_r, y1_r;
  logic signed [47:0] num1_nxt, den1_nxt, s1_nxt, y1_nxt;
  logic [MAG_W-1:0]   an2_r, ad2_r, an2_nxt, ad2_nxt;
  flags_t             flags2_r, flags2_nxt;
  logic [15:0]        lux2_r, lux2_nxt;

  assign en[1]   = !v_r[1] || m_ready;
  assign en[0]   = !v_r[0] || en[1];
  assign s_ready = en[0];
  assign m_valid = v_r[1];

  always_comb begin
    logic [15:0]        mx;
    logic [31:0]        rp;
    logic signed [47:0] cr, cg, cb;
    mx = s_chan[0];
    if (s_chan[1] > mx) mx = s_chan[1];
    if (s_chan[2] > mx) mx = s_chan[2];
    rp        = 32'(mx) * RECIP255;
    cdiv1_nxt = rp[31:23] + 9'd1;
    cr = $signed({32'd0, s_chan[0]});
    cg = $signed({32'd0, s_chan[1]});
    cb = $signed({32'd0, s_chan[2]});
    num1_nxt = NUM_R * cr + NUM_G * cg + NUM_B * cb;
    den1_nxt = DEN_R * cr + DEN_G * cg + DEN_B * cb;
    s1_nxt   = S_R * cr + S_G * cg + S_B * cb;
    y1_nxt   = Y_R * cr + Y_G * cg + Y_B * cb;
  end

  always_comb begin
    logic        y_pos, y_big;
    logic [27:0] y5;
    logic [56:0] lp;
    an2_nxt = num1_r[47] ? MAG_W'(-num1_r) : MAG_W'(num1_r);
    ad2_nxt = den1_r[47] ? MAG_W'(-den1_r) : MAG_W'(den1_r);
    flags2_nxt.tv  = (s1_r != '0) && (den1_r != '0);
    flags2_nxt.neg = num1_r[47] ^ den1_r[47];
    flags2_nxt.sat = {4'd0, an2_nxt} >= {ad2_nxt, 4'd0};
    // lux = Y / 100000 = (Y >> 5) / 3125
    y_pos = !y1_r[47] && (y1_r != '0);
    y_big = y1_r >= LUX_BIG;
    y5    = y1_r[32:5];
    lp    = 57'(y5) * LUX_K;
    if (!y_pos)     lux2_nxt = 16'd0;
    else if (y_big) lux2_nxt = SAT16;
    else            lux2_nxt = lp[55:40];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= s_valid;
      if (en[1]) v_r[1] <= v_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      chan1_r <= s_chan;
      cdiv1_r <= cdiv1_nxt;
      num1_r  <= num1_nxt;
      den1_r  <= den1_nxt;
      s1_r    <= s1_nxt;
      y1_r    <= y1_nxt;
    end
    if (en[1]) begin
      chan2_r  <= chan1_r;
      cdiv2_r  <= cdiv1_r;
      an2_r    <= an2_nxt;
      ad2_r    <= ad2_nxt;
      flags2_r <= flags2_nxt;
      lux2_r   <= lux2_nxt;
    end
  end

  assign m_chan    = chan2_r;
  assign m_cdiv    = cdiv2_r;
  assign m_num_mag = an2_r;
  assign m_den_mag = ad2_r;
  assign m_flags   = flags2_r;
  assign m_lux     = lux2_r;

endmodule

// ===== rtl/ccl_div.sv =====
// ----------------------------------------------------------------------------
// ccl_div
// Pipelined restoring divider, one quotient bit per stage: the McCamy ratio
// |num|/|den| in Q(FRAC_BITS), and in the first eight stages the three
// channel quotients c / div.
// ----------------------------------------------------------------------------
module ccl_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        s_valid,
  output logic                        s_ready,
  input  ccl_pkg::chan_t              s_chan,
  input  logic [ccl_pkg::DIVC_W-1:0]  s_cdiv,
  input  logic [ccl_pkg::MAG_W-1:0]   s_num_mag,
  input  logic [ccl_pkg::MAG_W-1:0]   s_den_mag,
  input  ccl_pkg::flags_t             s_flags,
  input  logic [15:0]                 s_lux,
  output logic                        m_valid,
  input  logic                        m_ready,
  output logic [FRAC_BITS+3:0]        m_q,
  output ccl_pkg::rgb_t               m_rgb,
  output ccl_pkg::flags_t             m_flags,
  output logic [15:0]                 m_lux
);
  import ccl_pkg::*;

  localparam int NS = FRAC_BITS + 4;  // 4 integer bits, FRAC_BITS fraction bits
  localparam int QW = NS;
  localparam int RW = MAG_W + 4;

  logic [NS-1:0]     v_r, v_nxt, en;
  logic [RW-1:0]     rem_r   [NS-1];
  logic [MAG_W-1:0]  ad_r    [NS-1];
  logic [QW-1:0]     q_r     [NS];
  chan_t             chrem_r [7];
  logic [DIVC_W-1:0] cdiv_r  [7];
  rgb_t              chq_r   [NS];
  flags_t            flags_r [NS];
  logic [15:0]       lux_r   [NS];

  logic [RW-1:0]     rem_nxt   [NS];
  logic [QW-1:0]     q_nxt     [NS];
  chan_t             chrem_nxt [8];
  rgb_t              chq_nxt   [NS];

  always_comb begin
    en[NS-1] = !v_r[NS-1] || m_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end
  assign s_ready = en[0];
  assign m_valid = v_r[NS-1];

  always_comb begin
    logic [RW-1:0]     rs, t, dd;
    logic [MAG_W-1:0]  ads;
    logic              ge;
    chan_t             crs;
    logic [DIVC_W-1:0] cds;
    logic [16:0]       cd;
    for (int i = 0; i < 8; i++) chrem_nxt[i] = '0;
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        rs         = RW'(s_num_mag);
        ads        = s_den_mag;
        q_nxt[k]   = '0;
        chq_nxt[k] = '0;
        v_nxt[k]   = s_valid;
      end else begin
        rs         = rem_r[k-1];
        ads        = ad_r[k-1];
        q_nxt[k]   = q_r[k-1];
        chq_nxt[k] = chq_r[k-1];
        v_nxt[k]   = v_r[k-1];
      end
      // integer bits compare against den << j, fraction bits shift the remainder
      if (k < 4) begin
        t  = rs;
        dd = RW'(ads) << (3 - k);
      end else begin
        t  = rs << 1;
        dd = RW'(ads);
      end
      ge                  = t >= dd;
      rem_nxt[k]          = ge ? t - dd : t;
      q_nxt[k][QW-1-k]    = ge;
      if (k < 8) begin
        if (k == 0) begin
          crs = s_chan;
          cds = s_cdiv;
        end else begin
          crs = chrem_r[k-1];
          cds = cdiv_r[k-1];
        end
        for (int c = 0; c < 3; c++) begin
          cd = 17'(cds) << (7 - k);
          if ({1'b0, crs[c]} >= cd) begin
            chrem_nxt[k][c]     = crs[c] - cd[15:0];
            chq_nxt[k][c][7-k]  = 1'b1;
          end else begin
            chrem_nxt[k][c]     = crs[c];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) v_r[k] <= v_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      q_r[0]     <= q_nxt[0];
      chq_r[0]   <= chq_nxt[0];
      flags_r[0] <= s_flags;
      lux_r[0]   <= s_lux;
      rem_r[0]   <= rem_nxt[0];
      ad_r[0]    <= s_den_mag;
      chrem_r[0] <= chrem_nxt[0];
      cdiv_r[0]  <= s_cdiv;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        q_r[k]     <= q_nxt[k];
        chq_r[k]   <= chq_nxt[k];
        flags_r[k] <= flags_r[k-1];
        lux_r[k]   <= lux_r[k-1];
        if (k < NS - 1) begin
          rem_r[k] <= rem_nxt[k];
          ad_r[k]  <= ad_r[k-1];
        end
        if (k < 7) begin
          chrem_r[k] <= chrem_nxt[k];
          cdiv_r[k]  <= cdiv_r[k-1];
        end
      end
    end
  end

  assign m_q     = q_r[NS-1];
  assign m_rgb   = chq_r[NS-1];
  assign m_flags = flags_r[NS-1];
  assign m_lux   = lux_r[NS-1];

endmodule

// ===== rtl/ccl_back.sv =====
// ----------------------------------------------------------------------------
// ccl_back
// Six stages: n^2 and RGB post-scale, n^3, cubic terms, sum, /100, clamp.
// ----------------------------------------------------------------------------
module ccl_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 s_valid,
  output logic                 s_ready,
  input  logic [FRAC_BITS+3:0] s_q,
  input  ccl_pkg::rgb_t        s_rgb,
  input  ccl_pkg::flags_t      s_flags,
  input  logic [15:0]          s_lux,
  output logic                 m_valid,
  input  logic                 m_ready,
  output ccl_pkg::rgb_t        m_rgb,
  output logic [15:0]          m_cct,
  output logic                 m_tv,
  output logic [15:0]          m_lux
);
  import ccl_pkg::*;

  localparam int MW  = FRAC_BITS + 5;
  localparam int N2W = FRAC_BITS + 9;
  localparam int N3W = FRAC_BITS + 13;
  localparam int PW  = FRAC_BITS + 32;

  localparam logic signed [PW-1:0] C1 = PW'(682330);
  localparam logic signed [PW-1:0] C2 = PW'(352500);
  localparam logic signed [PW-1:0] C3 = PW'(44900);
  localparam logic signed [PW-1:0] C0 = PW'(552033) << FRAC_BITS;

  logic [5:0] v_r, en;

  logic [MW-1:0]       mag1_r, mag1_nxt;
  logic [N2W-1:0]      n2_1_r, n2_1_nxt, n2_2_r;
  logic                neg1_r;
  side_t               sd1_r, sd1_nxt, sd2_r, sd3_r, sd4_r, sd5_r, sd6_r;
  logic signed [MW:0]  n1_2_r, n1_2_nxt;
  logic signed [N3W:0] n3_2_r, n3_2_nxt;
  logic signed [PW-1:0] t1_3_r, t2_3_r, t3_3_r;
  logic                pos4_r, big4_r, pos5_r, big5_r, pos4_nxt, big4_nxt;
  logic [22:0]         xs4_r, xs4_nxt;
  logic [46:0]         cp5_r;
  logic [15:0]         cct6_r, cct6_nxt;

  always_comb begin
    en[5] = !v_r[5] || m_ready;
    for (int k = 4; k >= 0; k--) en[k] = !v_r[k] || en[k+1];
  end
  assign s_ready = en[0];
  assign m_valid = v_r[5];

  // stage 1: clamp ratio, square it; finish the 8-bit channels
  always_comb begin
    logic [2*MW-1:0] sq;
    logic [7:0]      cv;
    logic [12:0]     w;
    logic [26:0]     pr;
    mag1_nxt = s_flags.sat ? (MW'(1) << (FRAC_BITS + 4)) : MW'(s_q);
    sq       = (2*MW)'(mag1_nxt) * (2*MW)'(mag1_nxt);
    n2_1_nxt = sq[FRAC_BITS +: N2W];
    for (int c = 0; c < 3; c++) begin
      cv = (s_rgb[c] > RGB_OFS) ? s_rgb[c] - RGB_OFS : s_rgb[c];
      w  = 13'(cv) * 13'd17;                 // v*255/225 = v*17/15
      pr = 27'(w) * RGB_K;
      sd1_nxt.rgb[c] = (pr[26:17] > 10'd255) ? 8'hFF : pr[24:17];
    end
    sd1_nxt.lux = s_lux;
    sd1_nxt.tv  = s_flags.tv;
  end

  // stage 2: cube, apply sign
  always_comb begin
    logic [N2W+MW-1:0] pc;
    logic [N3W-1:0]    n3m;
    pc  = (N2W+MW)'(n2_1_r) * (N2W+MW)'(mag1_r);
    n3m = pc[FRAC_BITS +: N3W];
    n1_2_nxt = neg1_r ? -$signed({1'b0, mag1_r}) : $signed({1'b0, mag1_r});
    n3_2_nxt = neg1_r ? -$signed({1'b0, n3m}) : $signed({1'b0, n3m});
  end

  // stage 4: sum, P / 2^F, range check ahead of the /100
  always_comb begin
    logic signed [PW-1:0] p;
    logic [31:0]          x;
    p        = t1_3_r + t2_3_r + t3_3_r + C0;
    pos4_nxt = !p[PW-1] && (p != '0);
    x        = p[PW-1:FRAC_BITS];
    big4_nxt = x >= CCT_BIG;
    xs4_nxt  = x[22:0];
  end

  always_comb begin
    if (!sd5_r.tv || !pos5_r) cct6_nxt = 16'd0;
    else if (big5_r)          cct6_nxt = SAT16;
    else                      cct6_nxt = cp5_r[45:30];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= s_valid;
      for (int k = 1; k < 6; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mag1_r <= mag1_nxt;
      n2_1_r <= n2_1_nxt;
      neg1_r <= s_flags.neg;
      sd1_r  <= sd1_nxt;
    end
    if (en[1]) begin
      n1_2_r <= n1_2_nxt;
      n2_2_r <= n2_1_r;
      n3_2_r <= n3_2_nxt;
      sd2_r  <= sd1_r;
    end
    if (en[2]) begin
      t1_3_r <= PW'(n1_2_r) * C1;
      t2_3_r <= $signed(PW'(n2_2_r)) * C2;
      t3_3_r <= PW'(n3_2_r) * C3;
      sd3_r  <= sd2_r;
    end
    if (en[3]) begin
      pos4_r <= pos4_nxt;
      big4_r <= big4_nxt;
      xs4_r  <= xs4_nxt;
      sd4_r  <= sd3_r;
    end
    if (en[4]) begin
      cp5_r  <= 47'(xs4_r) * CCT_K;
      pos5_r <= pos4_r;
      big5_r <= big4_r;
      sd5_r  <= sd4_r;
    end
    if (en[5]) begin
      cct6_r <= cct6_nxt;
      sd6_r  <= sd5_r;
    end
  end

  assign m_rgb = sd6_r.rgb;
  assign m_cct = cct6_r;
  assign m_tv  = sd6_r.tv;
  assign m_lux = sd6_r.lux;

endmodule

// ===== rtl/color_sensor_rgb_to_cct_lux_core.sv =====
// ----------------------------------------------------------------------------
// color_sensor_rgb_to_cct_lux_core
// Raw RGB sensor sample to 8-bit RGB, McCamy CCT and lux.
// ----------------------------------------------------------------------------
// Fully pipelined: one word in and one word out per cycle while out_tready
// is high, through 2 front stages, FRAC_BITS + 4 divider stages and 6
// back-end stages. The depth is set by the restoring ratio divider, which
// resolves one quotient bit per stage. Stalls on out_tready back up stage by
// stage; empty stages still take new words while a result waits.
`include "color_sensor_rgb_to_cct_lux_core_macros.svh"
module color_sensor_rgb_to_cct_lux_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // raw_red, raw_green, raw_blue
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // red_8bit, green_8bit, blue_8bit, color_temp, lux
  output logic        out_tuser   // temp_valid
);
  import ccl_pkg::*;

  chan_t             in_chan, f_chan;
  logic              f_valid, f_ready, d_valid, d_ready;
  logic [DIVC_W-1:0] f_cdiv;
  logic [MAG_W-1:0]  f_num_mag, f_den_mag;
  flags_t            f_flags, d_flags;
  logic [15:0]       f_lux, d_lux, o_lux, o_cct;
  logic [FRAC_BITS+3:0] d_q;
  rgb_t              d_rgb, o_rgb;
  logic              o_tv;

  assign in_chan = in_tdata;

  ccl_front u_front (
    .clk, .rst_n,
    .s_valid(in_tvalid), .s_ready(in_tready), .s_chan(in_chan),
    .m_valid(f_valid), .m_ready(f_ready), .m_chan(f_chan), .m_cdiv(f_cdiv),
    .m_num_mag(f_num_mag), .m_den_mag(f_den_mag), .m_flags(f_flags), .m_lux(f_lux)
  );

  ccl_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk, .rst_n,
    .s_valid(f_valid), .s_ready(f_ready), .s_chan(f_chan), .s_cdiv(f_cdiv),
    .s_num_mag(f_num_mag), .s_den_mag(f_den_mag), .s_flags(f_flags), .s_lux(f_lux),
    .m_valid(d_valid), .m_ready(d_ready), .m_q(d_q), .m_rgb(d_rgb),
    .m_flags(d_flags), .m_lux(d_lux)
  );

  ccl_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n,
    .s_valid(d_valid), .s_ready(d_ready), .s_q(d_q), .s_rgb(d_rgb),
    .s_flags(d_flags), .s_lux(d_lux),
    .m_valid(out_tvalid), .m_ready(out_tready), .m_rgb(o_rgb), .m_cct(o_cct),
    .m_tv(o_tv), .m_lux(o_lux)
  );

  assign out_tdata = {o_lux, o_cct, o_rgb};
  assign out_tuser = o_tv;

  `CCL_ASSERT_IMP(a_empty_out_ready, !out_tvalid, in_tready)
  `CCL_ASSERT_IMP(a_cct_zero_no_temp, out_tvalid && !out_tuser, out_tdata[39:24] == 16'd0)
  `CCL_ASSERT_NXT(a_reset_flushes, !rst_n, !out_tvalid)

endmodule
